// ----- sv/clcc_pkg.sv -----
// ----------------------------------------------------------------------------
// clcc_pkg
// Types and constants shared by the cornering lamp channel controller and
// its channel interfaces.
// ----------------------------------------------------------------------------
package clcc_pkg;

  localparam int CHANNELS  = 12;
  localparam int DUTY_W    = 7;
  localparam int DELAY_W   = 8;
  localparam int RAMP_W    = 16;
  localparam int TIMING_W  = 48;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = 2 * DUTY_W;

  localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;

  // x / 100 == (x * 10486) >> 20 for every x below 2^14
  localparam logic [14:0] DIV100_MUL   = 15'd10486;
  localparam int          DIV100_SHIFT = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_CORNER_MASK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FOG_MASK    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTENSITY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_TIMING  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FOG_TIMING  = 3'd5;

  localparam logic [1:0] GAMMA_STEP   = 2'd0;
  localparam logic [1:0] GAMMA_LINEAR = 2'd1;
  localparam logic [1:0] GAMMA_EXP    = 2'd2;

  localparam logic [1:0] STATUS_OFF   = 2'd0;
  localparam logic [1:0] STATUS_ON    = 2'd1;
  localparam logic [1:0] STATUS_ERROR = 2'd2;

  typedef struct packed {
    logic                activate;
    logic [7:0]          tick_time;
    logic [DUTY_W-1:0]   afs_level;
    logic [DUTY_W-1:0]   dbl_level;
    logic [DUTY_W-1:0]   fog_level;
    logic [4:0]          derate_flags;
    logic [CHANNELS-1:0] stored_fault_mask;
    logic [CHANNELS-1:0] live_fault_mask;
    logic [CHANNELS-1:0] sensor_fault_mask;
    logic [1:0]          one_fails_all;
  } in_item_t;

  typedef struct packed {
    logic [CHANNELS-1:0] kill_mask;
    logic                drive_valid;
    logic [CHANNELS-1:0] drive_mask;
    logic [DUTY_W-1:0]   drive_duty;
    logic [RAMP_W-1:0]   drive_on_ramp;
    logic [RAMP_W-1:0]   drive_off_ramp;
    logic                status_valid;
    logic [1:0]          lamp_status;
    logic                fog_owns;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [TIMING_W-1:0]  value;
  } cfg_write_t;

endpackage

// ----- sv/clcc_in_if.sv -----
// ----------------------------------------------------------------------------
// clcc_in_if
// Valid/ready channel carrying one control tick item.
// ----------------------------------------------------------------------------
interface clcc_in_if;
  logic               valid;
  logic               ready;
  clcc_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/clcc_out_if.sv -----
// ----------------------------------------------------------------------------
// clcc_out_if
// Valid/ready channel carrying one channel command and status item.
// ----------------------------------------------------------------------------
interface clcc_out_if;
  logic                valid;
  logic                ready;
  clcc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/clcc_cfg_if.sv -----
// ----------------------------------------------------------------------------
// clcc_cfg_if
// Valid/ready register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface clcc_cfg_if;
  logic                 valid;
  logic                 ready;
  clcc_pkg::cfg_write_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/cornering_lamp_channel_controller.sv -----
// ----------------------------------------------------------------------------
// cornering_lamp_channel_controller
// Per control tick: channel ownership between cornering and fog lamp, duty
// priority, on/off delay phases, fault exclusion and lamp status feedback.
// ----------------------------------------------------------------------------
//  port    dir  handshake      content
//  in_i    in   valid/ready    one control tick item
//  out_o   out  valid/ready    one command/status item per enabled tick
//  cfg_i   in   valid/ready    register index and write data
//
//  An item passes the input register, then one pass of tick logic into the
//  result register. One item per cycle sustained while out_o is ready; the
//  single tick pass with its scaling multiply sets that figure.
//  With a zero cornering channel mask an item is taken and dropped.
//  A stalled result holds and the input register still takes one item.
//  Reset is asynchronous and clears config, valid flags and tick state only.
// ----------------------------------------------------------------------------
module cornering_lamp_channel_controller (
  input  logic       clk_i,
  input  logic       rst_ni,
  clcc_in_if.sink    in_i,
  clcc_out_if.source out_o,
  clcc_cfg_if.sink   cfg_i
);
  import clcc_pkg::*;

  typedef enum logic [1:0] {
    PH_RUN,
    PH_ON_DLY,
    PH_OFF_DLY
  } phase_e;

  // configuration
  logic [CHANNELS-1:0] corner_mask_q, fog_mask_q;
  logic [DUTY_W-1:0]   intensity_q;
  logic [1:0]          gamma_q;
  logic [TIMING_W-1:0] own_timing_q, fog_timing_q;

  // input register
  logic                in_valid_q;
  logic                act_q;
  logic [7:0]          tick_q;
  logic [PROD_W-1:0]   afs_prod_q, dbl_prod_q;
  logic [DUTY_W-1:0]   fog_lvl_q;
  logic [4:0]          derate_q;
  logic [CHANNELS-1:0] stored_q, livef_q, sensf_q;
  logic [1:0]          nrule_q;

  // tick state
  logic                owner_q, owner_d;
  logic                cwas_q, cwas_d, fwas_q, fwas_d;
  logic [DUTY_W-1:0]   tgt_q, tgt_d;
  logic [CHANNELS-1:0] live_q, live_d;
  phase_e              phase_q, phase_d;
  logic [DELAY_W-1:0]  ondly_q, ondly_d, offdly_q, offdly_d;
  logic                act_last_q, act_last_d;
  logic [RAMP_W-1:0]   onramp_q, onramp_d, offramp_q, offramp_d;

  // result register
  logic                out_valid_q;
  out_item_t           out_q, res;

  logic advance, enabled, step;

  logic [27:0]         afs_scaled, dbl_scaled;
  logic [7:0]          afs_div, dbl_div;
  logic [DUTY_W-1:0]   afs_duty, dbl_duty, fog_duty, own_duty;
  logic                shared, corner_req, fog_req, n1, ramp_on;
  logic [TIMING_W-1:0] timing;
  logic [RAMP_W-1:0]   on_ramp, off_ramp, own_on, own_off;
  logic [DELAY_W-1:0]  on_dly, off_dly, on_sat, off_sat;
  logic [DELAY_W:0]    on_sum, off_sum;
  logic [RAMP_W:0]     onr_sum, offr_sum;
  logic                entry_on, entry_off, derating, err_cond;
  phase_e              phase_mid;
  logic [CHANNELS-1:0] live_mid, err_raw, err;

  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign enabled     = |corner_mask_q;
  assign step        = advance && enabled;
  assign in_i.ready  = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // scale AFS and DBL by intensity, then divide by 100
  assign afs_scaled = {14'b0, afs_prod_q} * {13'b0, DIV100_MUL};
  assign dbl_scaled = {14'b0, dbl_prod_q} * {13'b0, DIV100_MUL};
  assign afs_div    = afs_scaled[DIV100_SHIFT+7:DIV100_SHIFT];
  assign dbl_div    = dbl_scaled[DIV100_SHIFT+7:DIV100_SHIFT];
  assign afs_duty   = (afs_div > {1'b0, DUTY_MAX}) ? DUTY_MAX : afs_div[DUTY_W-1:0];
  assign dbl_duty   = (dbl_div > {1'b0, DUTY_MAX}) ? DUTY_MAX : dbl_div[DUTY_W-1:0];
  assign fog_duty   = (fog_lvl_q > DUTY_MAX) ? DUTY_MAX : fog_lvl_q;
  assign own_duty   = !act_q ? '0 : ((intensity_q > DUTY_MAX) ? DUTY_MAX : intensity_q);

  assign shared     = (corner_mask_q == fog_mask_q);
  assign corner_req = |dbl_duty || |afs_duty || |own_duty;
  assign fog_req    = |fog_duty;
  assign ramp_on    = (gamma_q == GAMMA_LINEAR) || (gamma_q == GAMMA_EXP);

  assign timing   = owner_d ? fog_timing_q : own_timing_q;
  assign n1       = owner_d ? nrule_q[1] : nrule_q[0];
  assign on_ramp  = ramp_on ? timing[15:0] : '0;
  assign off_ramp = ramp_on ? timing[31:16] : '0;
  assign on_dly   = timing[39:32];
  assign off_dly  = timing[47:40];
  assign own_on   = ramp_on ? own_timing_q[15:0] : '0;
  assign own_off  = ramp_on ? own_timing_q[31:16] : '0;

  assign on_sum   = {1'b0, ondly_q} + {1'b0, tick_q};
  assign off_sum  = {1'b0, offdly_q} + {1'b0, tick_q};
  assign on_sat   = on_sum[DELAY_W] ? '1 : on_sum[DELAY_W-1:0];
  assign off_sat  = off_sum[DELAY_W] ? '1 : off_sum[DELAY_W-1:0];
  assign onr_sum  = {1'b0, onramp_q} + {9'b0, tick_q};
  assign offr_sum = {1'b0, offramp_q} + {9'b0, tick_q};

  always_comb begin
    // ownership
    if (!shared) begin
      owner_d = 1'b0;
    end else if (fog_req) begin
      owner_d = 1'b1;
    end else if (corner_req) begin
      owner_d = 1'b0;
    end else if (fwas_q) begin
      owner_d = 1'b1;
    end else if (cwas_q) begin
      owner_d = 1'b0;
    end else begin
      owner_d = owner_q;
    end
    cwas_d = shared ? corner_req : cwas_q;
    fwas_d = shared ? fog_req : fwas_q;

    // target priority
    if (fog_req) begin
      tgt_d = fog_duty;
    end else if (|dbl_duty) begin
      tgt_d = dbl_duty;
    end else if (|afs_duty) begin
      tgt_d = afs_duty;
    end else begin
      tgt_d = own_duty;
    end

    entry_on  = (tgt_q == '0) && (tgt_d != '0);
    entry_off = (tgt_q != '0) && (tgt_d == '0);
    phase_mid = entry_on ? PH_ON_DLY : (entry_off ? PH_OFF_DLY : phase_q);
    live_mid  = entry_on ? corner_mask_q : live_q;

    // fault exclusion
    derating = (tgt_d != '0) && (derate_q != '0);
    err_raw  = live_mid & stored_q;
    err      = (n1 && |err_raw) ? live_mid : err_raw;
    res      = '0;
    if (tgt_d == '0) begin
      live_d = live_mid;
    end else if (derating) begin
      live_d        = live_mid;
      res.kill_mask = live_mid;
    end else begin
      live_d        = live_mid ^ err;
      res.kill_mask = err;
    end

    // delay phases and drive command
    phase_d  = phase_mid;
    ondly_d  = ondly_q;
    offdly_d = offdly_q;
    if (!derating) begin
      case (phase_mid)
        PH_ON_DLY: begin
          if (on_sat >= on_dly) begin
            ondly_d = '0;
            phase_d = PH_RUN;
          end else begin
            ondly_d = on_sat;
          end
        end
        PH_OFF_DLY: begin
          if (off_sat >= off_dly) begin
            offdly_d = '0;
            phase_d  = PH_RUN;
          end else begin
            offdly_d = off_sat;
          end
        end
        default: begin
          res.drive_valid    = 1'b1;
          res.drive_mask     = live_d;
          res.drive_duty     = tgt_d;
          res.drive_on_ramp  = on_ramp;
          res.drive_off_ramp = off_ramp;
        end
      endcase
    end

    // status feedback
    err_cond = |derate_q[4:2] || |(corner_mask_q & livef_q) ||
               |(corner_mask_q & sensf_q) || (live_d != corner_mask_q);
    act_last_d = act_q;
    onramp_d   = onramp_q;
    offramp_d  = offramp_q;
    if (owner_d) begin
      res.status_valid = 1'b1;
      res.lamp_status  = STATUS_OFF;
    end else if (act_q != act_last_q) begin
      onramp_d  = '0;
      offramp_d = '0;
    end else if (act_q) begin
      if (onramp_q < own_on) begin
        onramp_d = onr_sum[RAMP_W] ? '1 : onr_sum[RAMP_W-1:0];
      end else begin
        res.status_valid = 1'b1;
        res.lamp_status  = err_cond ? STATUS_ERROR : STATUS_ON;
      end
    end else begin
      if (offramp_q < own_off) begin
        offramp_d = offr_sum[RAMP_W] ? '1 : offr_sum[RAMP_W-1:0];
      end else begin
        res.status_valid = 1'b1;
        res.lamp_status  = STATUS_OFF;
      end
    end
    res.fog_owns = owner_d;
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      act_q      <= in_i.data.activate;
      tick_q     <= in_i.data.tick_time;
      afs_prod_q <= {{DUTY_W{1'b0}}, in_i.data.afs_level} * {{DUTY_W{1'b0}}, intensity_q};
      dbl_prod_q <= {{DUTY_W{1'b0}}, in_i.data.dbl_level} * {{DUTY_W{1'b0}}, intensity_q};
      fog_lvl_q  <= in_i.data.fog_level;
      derate_q   <= in_i.data.derate_flags;
      stored_q   <= in_i.data.stored_fault_mask;
      livef_q    <= in_i.data.live_fault_mask;
      sensf_q    <= in_i.data.sensor_fault_mask;
      nrule_q    <= in_i.data.one_fails_all;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_mask_q <= '0;
      fog_mask_q    <= '0;
      intensity_q   <= DUTY_MAX;
      gamma_q       <= GAMMA_STEP;
      own_timing_q  <= '0;
      fog_timing_q  <= '0;
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      owner_q       <= 1'b0;
      cwas_q        <= 1'b0;
      fwas_q        <= 1'b0;
      tgt_q         <= '0;
      live_q        <= '0;
      phase_q       <= PH_RUN;
      ondly_q       <= '0;
      offdly_q      <= '0;
      act_last_q    <= 1'b0;
      onramp_q      <= '0;
      offramp_q     <= '0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.data.index)
          CFG_CORNER_MASK: corner_mask_q <= cfg_i.data.value[CHANNELS-1:0];
          CFG_FOG_MASK:    fog_mask_q    <= cfg_i.data.value[CHANNELS-1:0];
          CFG_INTENSITY:   intensity_q   <= cfg_i.data.value[DUTY_W-1:0];
          CFG_GAMMA:       gamma_q       <= cfg_i.data.value[1:0];
          CFG_OWN_TIMING:  own_timing_q  <= cfg_i.data.value;
          CFG_FOG_TIMING:  fog_timing_q  <= cfg_i.data.value;
          default: ;
        endcase
      end

      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end

      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      if (step) begin
        owner_q    <= owner_d;
        cwas_q     <= cwas_d;
        fwas_q     <= fwas_d;
        tgt_q      <= tgt_d;
        live_q     <= live_d;
        phase_q    <= phase_d;
        ondly_q    <= ondly_d;
        offdly_q   <= offdly_d;
        act_last_q <= act_last_d;
        onramp_q   <= onramp_d;
        offramp_q  <= offramp_d;
      end
    end
  end

  a_drive_fields_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.drive_valid) |->
      (out_q.drive_mask == '0 && out_q.drive_duty == '0 &&
       out_q.drive_on_ramp == '0 && out_q.drive_off_ramp == '0))
    else $error("drive fields set without drive command");

  a_kill_drive_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.drive_valid) |-> ((out_q.kill_mask & out_q.drive_mask) == '0))
    else $error("killed channel still driven");

  a_fog_owner_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.fog_owns) |->
      (out_q.status_valid && out_q.lamp_status == STATUS_OFF))
    else $error("fog owner must report lamp off");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled result changed");

  a_disabled_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !enabled && (!out_valid_q || out_o.ready)) |=> !out_valid_q)
    else $error("result produced while disabled");

endmodule
